>>> design/fscpb_pkg.sv
// ----------------------------------------------------------------------------
// fscpb_pkg: shared types, constants and helpers
// Register map, queue entry, state encodings and small arithmetic helpers for
// the fit/scale/center pixel blitter.
// ----------------------------------------------------------------------------
package fscpb_pkg;

  localparam int unsigned MAX_SIDE    = 8192;
  localparam int unsigned SIDE_W      = 14;
  localparam int unsigned PITCH_W     = 17;
  localparam int unsigned BITS_W      = 6;
  localparam int unsigned LAYOUT_W    = 36;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned OFFSET_W    = 30;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned NBYTES_W    = 3;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned QUOT_W      = SIDE_W + FRAC_W;
  localparam int unsigned SCALE_W     = FRAC_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(QUOT_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned APB_AW      = 6;
  localparam int unsigned APB_DW      = 64;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_PITCH    = 3'd2,
    REG_PIX_BITS = 3'd3,
    REG_IMAGE_W  = 3'd4,
    REG_IMAGE_H  = 3'd5,
    REG_LAYOUT   = 3'd6
  } reg_idx_e;

  localparam logic [BITS_W-1:0] DEPTH_16 = 6'd16;
  localparam logic [BITS_W-1:0] DEPTH_24 = 6'd24;
  localparam logic [BITS_W-1:0] DEPTH_32 = 6'd32;

  typedef struct packed {
    logic [SIDE_W-1:0]   screen_w;
    logic [SIDE_W-1:0]   screen_h;
    logic [PITCH_W-1:0]  pitch;
    logic [BITS_W-1:0]   pix_bits;
    logic [SIDE_W-1:0]   image_w;
    logic [SIDE_W-1:0]   image_h;
    logic [LAYOUT_W-1:0] layout;
  } cfg_t;

  // One pixel write still to be formatted
  typedef struct packed {
    logic [RGB_W-1:0]  rgb;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
  } wr_item_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_FIT,
    F_DIVX,
    F_DIVY,
    F_SCALE_W,
    F_SCALE_H,
    F_CENTER,
    F_MUL,
    F_DECIDE
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_PACK,
    B_FMT,
    B_OUT
  } back_state_e;

  // Zero counts as 1, anything above MAX_SIDE as MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  // (2^k-1) = 255*q + r with q = sum of 2^(k-8j), r = 2^(k mod 8)-1
  function automatic logic [DATA_W-1:0] mask_quot(input logic [5:0] k);
    logic [5:0]        kk;
    logic [DATA_W-1:0] q;
    kk = (k >= 6'd32) ? 6'd32 : k;
    q  = '0;
    for (int j = 1; j <= 4; j++) begin
      if (6'(8 * j) <= kk) q = q | (DATA_W'(1) << (kk - 6'(8 * j)));
    end
    return q;
  endfunction

  function automatic logic [7:0] mask_rem(input logic [5:0] k);
    logic [8:0] p;
    p = 9'd1 << k[2:0];
    return (k >= 6'd32) ? 8'd0 : 8'(p - 9'd1);
  endfunction

  // floor(y/255), exact for y below 65280
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] t;
    t = 17'(y) + 17'(y[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [NBYTES_W-1:0] depth_bytes(input logic [BITS_W-1:0] b);
    logic [NBYTES_W-1:0] n;
    case (b)
      DEPTH_32: n = 3'd4;
      DEPTH_24: n = 3'd3;
      DEPTH_16: n = 3'd2;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> design/fscpb_fifo.sv
// ----------------------------------------------------------------------------
// fscpb_fifo: write queue
// Short FIFO of pending pixel writes between the front and back sections.
// ----------------------------------------------------------------------------
module fscpb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fscpb_pkg::wr_item_t push_data_i,
  input  logic                pop_i,
  output fscpb_pkg::wr_item_t pop_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import fscpb_pkg::*;

  wr_item_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;

  assign full_o     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> design/fscpb_front.sv
// ----------------------------------------------------------------------------
// fscpb_front: frame fit and pixel selection
// Accepts source pixels, fits the image at frame start with a serial
// divider, decides which source pixels are drawn and queues their writes.
// ----------------------------------------------------------------------------
module fscpb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fscpb_pkg::cfg_t       cfg_i,
  input  logic                  pixel_valid_i,
  output logic                  pixel_ready_o,
  input  logic [23:0]           pixel_rgb_i,
  output logic                  push_o,
  output fscpb_pkg::wr_item_t   push_data_o,
  input  logic                  full_i
);
  import fscpb_pkg::*;

  front_state_e state_q, state_d;

  logic [SIDE_W-1:0] sw, sh, iw, ih, fw, fh;
  logic [SIDE_W-1:0] scol_q, srow_q, fit_w_q, fit_h_q, cx_q, cy_q, ndc_q, ndr_q;
  logic [RGB_W-1:0]  rgb_q;

  // serial divider
  logic [QUOT_W-1:0]    quo_q, quo_step;
  logic [SIDE_W-1:0]    rem_q, rem_step, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SIDE_W:0]      r2;
  logic                 ge;
  logic [QUOT_W-1:0]    sx_q, smin;
  logic [SCALE_W-1:0]   s_q;
  logic                 div_last;

  // products for the pick test
  logic [2*SIDE_W-1:0] pr_q, lr_q, pc_q, lc_q;

  logic                row_hit, col_hit, on_screen, depth_ok, wr_ok, advance;
  logic [SIDE_W:0]     x_sum, y_sum;
  logic [2*SIDE_W-1+SCALE_W-SIDE_W:0] wprod;
  logic [SIDE_W-1:0]   fit_side;

  assign sw = clamp_side(cfg_i.screen_w);
  assign sh = clamp_side(cfg_i.screen_h);
  assign iw = clamp_side(cfg_i.image_w);
  assign ih = clamp_side(cfg_i.image_h);
  assign fw = (fit_w_q == '0) ? SIDE_W'(1) : fit_w_q;
  assign fh = (fit_h_q == '0) ? SIDE_W'(1) : fit_h_q;

  assign r2       = {rem_q, quo_q[QUOT_W-1]};
  assign ge       = (r2 >= {1'b0, den_q});
  assign rem_step = ge ? SIDE_W'(r2 - {1'b0, den_q}) : r2[SIDE_W-1:0];
  assign quo_step = {quo_q[QUOT_W-2:0], ge};
  assign div_last = (cnt_q == DIV_CNT_W'(QUOT_W - 1));
  assign smin     = (sx_q < quo_step) ? sx_q : quo_step;

  // fitted side = (side*s)>>16, at least 1
  assign wprod    = (state_q == F_SCALE_W) ? iw * s_q : ih * s_q;
  assign fit_side = (wprod[FRAC_W +: SIDE_W+1] == '0) ? SIDE_W'(1)
                                                      : SIDE_W'(wprod[FRAC_W +: SIDE_W+1]);

  assign row_hit = (ndr_q < fh) && (lr_q <= pr_q) &&
                   ((2*SIDE_W+1)'(pr_q) < (2*SIDE_W+1)'(lr_q) + (2*SIDE_W+1)'(fh));
  assign col_hit = row_hit && (ndc_q < fw) && (lc_q <= pc_q) &&
                   ((2*SIDE_W+1)'(pc_q) < (2*SIDE_W+1)'(lc_q) + (2*SIDE_W+1)'(fw));
  assign x_sum     = (SIDE_W+1)'(cx_q) + (SIDE_W+1)'(ndc_q);
  assign y_sum     = (SIDE_W+1)'(cy_q) + (SIDE_W+1)'(ndr_q);
  assign on_screen = (x_sum < (SIDE_W+1)'(sw)) && (y_sum < (SIDE_W+1)'(sh));
  assign depth_ok  = (depth_bytes(cfg_i.pix_bits) != '0);
  assign wr_ok     = col_hit && on_screen && depth_ok;
  assign advance   = (state_q == F_DECIDE) && !(wr_ok && full_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (pixel_valid_i) begin
          state_d = (scol_q == '0 && srow_q == '0) ? F_FIT : F_MUL;
        end
      end
      F_FIT:     state_d = (iw > sw || ih > sh) ? F_DIVX : F_CENTER;
      F_DIVX:    if (div_last) state_d = F_DIVY;
      F_DIVY:    if (div_last) state_d = F_SCALE_W;
      F_SCALE_W: state_d = F_SCALE_H;
      F_SCALE_H: state_d = F_CENTER;
      F_CENTER:  state_d = F_MUL;
      F_MUL:     state_d = F_DECIDE;
      F_DECIDE:  if (advance) state_d = F_IDLE;
      default:   state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pixel_ready_o = (state_q == F_IDLE);
    push_o        = advance && wr_ok;
    push_data_o   = '{rgb: rgb_q, x: x_sum[SIDE_W-1:0], y: y_sum[SIDE_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      scol_q  <= '0;
      srow_q  <= '0;
      fit_w_q <= '0;
      fit_h_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      ndc_q   <= '0;
      ndr_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_FIT: begin
          fit_w_q <= iw;
          fit_h_q <= ih;
        end
        F_SCALE_W: fit_w_q <= fit_side;
        F_SCALE_H: fit_h_q <= fit_side;
        F_CENTER: begin
          cx_q  <= (sw > fit_w_q) ? SIDE_W'((sw - fit_w_q) >> 1) : '0;
          cy_q  <= (sh > fit_h_q) ? SIDE_W'((sh - fit_h_q) >> 1) : '0;
          ndc_q <= '0;
          ndr_q <= '0;
        end
        F_DECIDE: begin
          if (advance) begin
            if ((SIDE_W+1)'(scol_q) + 1'b1 >= (SIDE_W+1)'(iw)) begin
              scol_q <= '0;
              ndc_q  <= '0;
              if (row_hit) ndr_q <= ndr_q + 1'b1;
              srow_q <= ((SIDE_W+1)'(srow_q) + 1'b1 >= (SIDE_W+1)'(ih)) ? '0
                                                                         : srow_q + 1'b1;
            end else begin
              scol_q <= scol_q + 1'b1;
              if (col_hit) ndc_q <= ndc_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && pixel_valid_i) rgb_q <= pixel_rgb_i;
    case (state_q)
      F_FIT: begin
        quo_q <= {sw, FRAC_W'(0)};
        rem_q <= '0;
        den_q <= iw;
        cnt_q <= '0;
      end
      F_DIVX: begin
        if (div_last) begin
          sx_q  <= quo_step;
          quo_q <= {sh, FRAC_W'(0)};
          rem_q <= '0;
          den_q <= ih;
          cnt_q <= '0;
        end else begin
          quo_q <= quo_step;
          rem_q <= rem_step;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      F_DIVY: begin
        quo_q <= quo_step;
        rem_q <= rem_step;
        cnt_q <= cnt_q + 1'b1;
        if (div_last) s_q <= (smin == '0) ? SCALE_W'(1) : SCALE_W'(smin);
      end
      F_MUL: begin
        pr_q <= ndr_q * ih;
        lr_q <= srow_q * fh;
        pc_q <= ndc_q * iw;
        lc_q <= scol_q * fw;
      end
      default: ;
    endcase
  end

endmodule

>>> design/fscpb_back.sv
// ----------------------------------------------------------------------------
// fscpb_back: write formatter
// Packs the color into the channel layout, forms 32/24/565 data and the
// framebuffer byte offset, and holds the result until taken.
// ----------------------------------------------------------------------------
module fscpb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fscpb_pkg::cfg_t      cfg_i,
  input  fscpb_pkg::wr_item_t  item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [29:0]          byte_offset_o,
  output logic [31:0]          write_data_o,
  output logic [2:0]           write_bytes_o
);
  import fscpb_pkg::*;

  back_state_e state_q, state_d;

  wr_item_t            e_q;
  logic [DATA_W-1:0]   cq_q [3];
  logic [15:0]         cr_q [3];
  logic [SIDE_W+PITCH_W-1:0] yp_q;
  logic [15:0]         xb_q;
  logic [DATA_W-1:0]   px_q;
  logic [OFFSET_W-1:0] off_q;
  logic [DATA_W-1:0]   data_q;
  logic [NBYTES_W-1:0] nb_q;

  logic [5:0]          size [3];
  logic [5:0]          pos  [3];
  logic [7:0]          chan [3];
  logic [DATA_W-1:0]   shifted [3];
  logic [DATA_W-1:0]   v [3];
  logic [NBYTES_W-1:0] nbytes;
  logic                all_sized;
  logic [DATA_W-1:0]   fmt;
  logic [15:0]         r31, g63, b31;
  logic [7:0]          r5, g6, b5;

  assign nbytes = depth_bytes(cfg_i.pix_bits);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      size[k]    = cfg_i.layout[6*k +: 6];
      pos[k]     = cfg_i.layout[6*(k+3) +: 6];
      chan[k]    = e_q.rgb[8*(2-k) +: 8];
      v[k]       = cq_q[k] + DATA_W'(div255(cr_q[k]));
      shifted[k] = (pos[k] >= 6'd32) ? '0 : (v[k] << pos[k][4:0]);
    end
    all_sized = (size[0] != '0) && (size[1] != '0) && (size[2] != '0);
  end

  // 565 from the packed word read back as 888
  always_comb begin
    r31 = 16'(px_q[23:16]) * 16'd31;
    g63 = 16'(px_q[15:8]) * 16'd63;
    b31 = 16'(px_q[7:0]) * 16'd31;
    r5  = div255(r31);
    g6  = div255(g63);
    b5  = div255(b31);
    case (cfg_i.pix_bits)
      DEPTH_32: fmt = px_q;
      DEPTH_24: fmt = {8'd0, px_q[23:0]};
      DEPTH_16: fmt = {16'd0, r5[4:0], g6[5:0], b5[4:0]};
      default:  fmt = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_MUL;
      B_MUL:   state_d = B_PACK;
      B_PACK:  state_d = B_FMT;
      B_FMT:   state_d = B_OUT;
      B_OUT:   if (out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o         = (state_q == B_IDLE) && !empty_i;
    out_valid_o   = (state_q == B_OUT);
    byte_offset_o = off_q;
    write_data_o  = data_q;
    write_bytes_o = nb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (!empty_i) e_q <= item_i;
      B_MUL: begin
        for (int k = 0; k < 3; k++) begin
          cq_q[k] <= DATA_W'(40'(chan[k]) * 40'(mask_quot(size[k])));
          cr_q[k] <= 16'(chan[k]) * 16'(mask_rem(size[k]));
        end
        yp_q <= e_q.y * cfg_i.pitch;
        xb_q <= 16'(e_q.x) * 16'(nbytes);
      end
      B_PACK: begin
        px_q  <= all_sized ? (shifted[0] | shifted[1] | shifted[2])
                           : {8'd0, e_q.rgb};
        off_q <= OFFSET_W'(yp_q + (SIDE_W+PITCH_W)'(xb_q));
      end
      B_FMT: begin
        data_q <= fmt;
        nb_q   <= nbytes;
      end
      default: ;
    endcase
  end

endmodule

>>> design/fit_scale_center_pixel_blitter.sv
// ----------------------------------------------------------------------------
// fit_scale_center_pixel_blitter: nearest-neighbor fit-and-center scaler
// Takes source pixels in raster order and emits framebuffer writes for the
// pixels picked by the fitted, centered destination image.
// ----------------------------------------------------------------------------
//  channel   handshake                     beat contents
//  pixel in  pixel_valid_i / pixel_ready_o pixel_rgb_i
//  write out out_valid_o / out_ready_i     byte_offset_o, write_data_o,
//                                          write_bytes_o
//  config    APB psel/penable/pwrite       paddr (8 bytes/reg), pwdata, prdata
//
// A pixel passes the front through accept, multiply and decide states; the
// first pixel of a frame also fits and centers, with two 30-step serial
// divisions when the image must shrink. The back formatter takes each write
// through multiply, pack, format and output states. A 2-entry queue between
// them lets the front take pixels, until it fills, while a write waits at the
// output. Reset is asynchronous, active low; it clears position, fit size and offsets.
// ----------------------------------------------------------------------------
module fit_scale_center_pixel_blitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // source pixels
  input  logic        pixel_valid_i,
  output logic        pixel_ready_o,
  input  logic [23:0] pixel_rgb_i,
  // framebuffer writes
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] byte_offset_o,
  output logic [31:0] write_data_o,
  output logic [2:0]  write_bytes_o
);
  import fscpb_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  logic     push, pop, full, empty;
  wr_item_t push_data, pop_data;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register readback
  always_comb begin
    case (idx)
      REG_SCREEN_W: prdata = 64'(cfg_q.screen_w);
      REG_SCREEN_H: prdata = 64'(cfg_q.screen_h);
      REG_PITCH:    prdata = 64'(cfg_q.pitch);
      REG_PIX_BITS: prdata = 64'(cfg_q.pix_bits);
      REG_IMAGE_W:  prdata = 64'(cfg_q.image_w);
      REG_IMAGE_H:  prdata = 64'(cfg_q.image_h);
      REG_LAYOUT:   prdata = 64'(cfg_q.layout);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w <= SIDE_W'(1024);
      cfg_q.screen_h <= SIDE_W'(768);
      cfg_q.pitch    <= PITCH_W'(4096);
      cfg_q.pix_bits <= DEPTH_32;
      cfg_q.image_w  <= SIDE_W'(640);
      cfg_q.image_h  <= SIDE_W'(480);
      cfg_q.layout   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SCREEN_W: cfg_q.screen_w <= pwdata[SIDE_W-1:0];
        REG_SCREEN_H: cfg_q.screen_h <= pwdata[SIDE_W-1:0];
        REG_PITCH:    cfg_q.pitch    <= pwdata[PITCH_W-1:0];
        REG_PIX_BITS: cfg_q.pix_bits <= pwdata[BITS_W-1:0];
        REG_IMAGE_W:  cfg_q.image_w  <= pwdata[SIDE_W-1:0];
        REG_IMAGE_H:  cfg_q.image_h  <= pwdata[SIDE_W-1:0];
        REG_LAYOUT:   cfg_q.layout   <= pwdata[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: fit at frame start, pick test, queue the writes
  fscpb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_rgb_i   (pixel_rgb_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  fscpb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back: color packing, offset, output register
  fscpb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (pop_data),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_offset_o (byte_offset_o),
    .write_data_o  (write_data_o),
    .write_bytes_o (write_bytes_o)
  );

endmodule
